FILE: rtl/core/rsort_pkg.sv
package rsort_pkg;

	// set size and field widths
	localparam int CAPACITY = 64;
	localparam int VALUE_W  = 31;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// one input transfer
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} in_item_t;

	// one result transfer
	typedef struct packed {
		logic [VALUE_W-1:0] sorted_value;
		logic               last_out;
		logic               truncated;
	} out_item_t;

	// contents of one cell as seen by its neighbors
	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
	} cell_data_t;

	// command broadcast to every cell
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

FILE: rtl/core/rsort_cell.sv
module rsort_cell
	import rsort_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [VALUE_W-1:0] new_value,
	input  logic               left_gt,
	input  cell_data_t         left_data,
	input  cell_data_t         right_data,
	output logic               gt,
	output cell_data_t         data
);

	logic               valid_q;
	logic [VALUE_W-1:0] value_q;

	// new value belongs in front of this entry (empty cells act as +inf)
	assign gt = !valid_q || (new_value < value_q);

	assign data.valid = valid_q;
	assign data.value = value_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_data.valid;
		end else if (ctl.insert) begin
			if (left_gt) begin
				valid_q <= left_data.valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end
	end

	// stored value: shift right on insert, shift left on drain
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= right_data.value;
		end else if (ctl.insert) begin
			if (left_gt) begin
				value_q <= left_data.value;
			end else if (gt) begin
				value_q <= new_value;
			end
		end
	end

endmodule

FILE: rtl/core/rsort_ctrl.sv
module rsort_ctrl
	import rsort_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               item_last,
	input  logic [VALUE_W-1:0] head_value,
	output logic               busy,
	output cell_ctl_t          ctl,
	output logic               result_strobe,
	output out_item_t          result
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             accept;
	logic             full;
	logic             final_out;
	logic             strobe_q;
	out_item_t        result_q;

	assign busy          = (state_q == ST_DRAIN);
	assign accept        = start && (state_q == ST_LOAD);
	assign full          = (count_q == CNT_W'(CAPACITY));
	assign final_out     = (count_q == CNT_W'(1));
	assign result_strobe = strobe_q;
	assign result        = result_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and cell commands
	always_comb begin
		state_d    = state_q;
		ctl.insert = 1'b0;
		ctl.shift  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				ctl.insert = accept && !full;
				if (accept && item_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				ctl.shift = 1'b1;
				if (final_out) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// fill count, doubles as remaining count while draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (ctl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.shift) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept && full) begin
				ovf_q <= 1'b1;
			end else if (ctl.shift && final_out) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.shift;
		end
	end

	// result payload, taken from the head cell
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			result_q.sorted_value <= head_value;
			result_q.last_out     <= final_out;
			result_q.truncated    <= ovf_q;
		end
	end

endmodule

FILE: rtl/core/radix_sorter_core.sv
// Sorter for sets of up to CAPACITY (64) unsigned 31-bit values. Each start
// with busy low transfers one value in one cycle; values are kept in ascending
// order in a row of compare-and-shift cells as they arrive, so loading costs
// one cycle per value. The value flagged last closes the set; busy then rises
// and the set drains from the head of the row, one result per cycle, each on
// the result ports for one cycle under result_strobe, the final one with
// last_out set. Results leave by the single drain port at the head cell.
// Values offered once the row is full are dropped and every result of that
// set carries truncated. The receiver must take each result in the cycle it
// is shown; a new set may start while the final result is shown.
module radix_sorter_core
	import rsort_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      result_strobe,
	output out_item_t result
);

	cell_ctl_t  ctl;
	cell_data_t data   [CAPACITY];
	logic       gt     [CAPACITY];
	cell_data_t right_d[CAPACITY];
	cell_data_t left_d [CAPACITY];
	logic       left_g [CAPACITY];

	// neighbor wiring, row ends tied to empty
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == 0) begin
				left_d[i] = '0;
				left_g[i] = 1'b0;
			end else begin
				left_d[i] = data[i-1];
				left_g[i] = gt[i-1];
			end
			if (i == CAPACITY - 1) begin
				right_d[i] = '0;
			end else begin
				right_d[i] = data[i+1];
			end
		end
	end

	// row of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		rsort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_value  (item.value),
			.left_gt    (left_g[g]),
			.left_data  (left_d[g]),
			.right_data (right_d[g]),
			.gt         (gt[g]),
			.data       (data[g])
		);
	end

	// sequencing and result register
	rsort_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.item_last     (item.last),
		.head_value    (data[0].value),
		.busy          (busy),
		.ctl           (ctl),
		.result_strobe (result_strobe),
		.result        (result)
	);

`ifndef SYNTHESIS
	// draining only follows a transfer that closed the set
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && item.last))
		else $error("busy rose without a closing transfer");

	// a non-final result always leaves more of the set draining
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.last_out) |-> busy)
		else $error("drain ended before the final result");

	// the final result frees the block for the next set
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last_out) |-> !busy)
		else $error("block still busy at the final result");

	// results come only out of a drain cycle
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without a drain cycle");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import rsort_pkg::*;

	typedef logic [VALUE_W-1:0] value_t;

	localparam value_t VALUE_MAX   = {VALUE_W{1'b1}};
	localparam int     CYCLE_LIMIT = 200000;
	localparam int     GAP_MAX     = 12;
	localparam int     RADIX       = 10;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      result_strobe;
	out_item_t result;

	// set being gathered, as the sorter sees it
	value_t    gathered_vals[$];
	logic      gathered_dropped;
	// sorted results still to come out of the block
	out_item_t sorted_due[$];

	int        sender_idle_pct;
	int        error_count;
	int        cycle_count;
	value_t    prev_value;

	radix_sorter_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// decimal lsd sort of the gathered set, queued as expected results
	task automatic close_set();
		value_t          vals[$];
		value_t          scratch[CAPACITY];
		value_t          largest;
		int              counts[RADIX];
		int              n;
		int              d;
		longint unsigned place;
		out_item_t       res;
		vals = gathered_vals;
		n = vals.size();
		largest = '0;
		foreach (vals[i])
			if (vals[i] > largest)
				largest = vals[i];
		for (place = 1; (longint'(largest) / place) > 0; place = place * RADIX) begin
			foreach (counts[k])
				counts[k] = 0;
			for (int i = 0; i < n; i++) begin
				d = int'((longint'(vals[i]) / place) % RADIX);
				counts[d]++;
			end
			for (int k = 1; k < RADIX; k++)
				counts[k] += counts[k-1];
			// place from the back to keep it stable
			for (int i = n - 1; i >= 0; i--) begin
				d = int'((longint'(vals[i]) / place) % RADIX);
				counts[d]--;
				scratch[counts[d]] = vals[i];
			end
			for (int i = 0; i < n; i++)
				vals[i] = scratch[i];
		end
		for (int i = 0; i < n; i++) begin
			res.sorted_value = vals[i];
			res.last_out     = (i == n - 1);
			res.truncated    = gathered_dropped;
			sorted_due.push_back(res);
		end
		gathered_vals.delete();
		gathered_dropped = 1'b0;
	endtask

	// one input transfer, then a random gap
	task automatic send_item(input value_t v, input logic is_last);
		in_item_t tx;
		int       gap;
		tx.value = v;
		tx.last  = is_last;
		start <= 1'b1;
		item  <= tx;
		do @(posedge clk); while (busy);
		if (gathered_vals.size() < CAPACITY)
			gathered_vals.push_back(v);
		else
			gathered_dropped = 1'b1;
		if (is_last)
			close_set();
		gap = 0;
		while (gap < GAP_MAX && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// value mix: full range, few digits, powers of ten, extremes, repeats
	function automatic value_t pick_value();
		value_t v;
		longint unsigned p;
		int     k;
		case ($urandom_range(5))
			0: v = value_t'($urandom);
			1: v = value_t'($urandom_range(9));
			2: v = value_t'($urandom_range(999));
			3: begin
				k = $urandom_range(9);
				p = 1;
				repeat (k) p = p * RADIX;
				v = value_t'(p - longint'($urandom_range(1)));
			end
			4: v = $urandom_range(1) ? VALUE_MAX : '0;
			default: v = prev_value;
		endcase
		prev_value = v;
		return v;
	endfunction

	task automatic send_set(input int size);
		for (int i = 0; i < size; i++)
			send_item(pick_value(), i == size - 1);
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_strobe) begin
			if (sorted_due.size() == 0) begin
				$error("unexpected result: sorted_value %0d", result.sorted_value);
				error_count++;
			end else begin
				want = sorted_due.pop_front();
				if (result.sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						want.sorted_value, result.sorted_value);
					error_count++;
				end
				if (result.last_out !== want.last_out) begin
					$error("last_out: expected %0b, got %0b", want.last_out, result.last_out);
					error_count++;
				end
				if (result.truncated !== want.truncated) begin
					$error("truncated: expected %0b, got %0b",
						want.truncated, result.truncated);
					error_count++;
				end
			end
		end
	end

	// one-element sets at the extremes
	task automatic test_single_values();
		send_item('0, 1'b1);
		send_item(VALUE_MAX, 1'b1);
		send_item(value_t'(1), 1'b1);
	endtask

	// ten-digit values, all zeros (no digit pass), duplicates
	task automatic test_digit_extremes();
		send_item(VALUE_MAX, 1'b0);
		send_item('0, 1'b0);
		send_item(value_t'(1000000000), 1'b0);
		send_item(value_t'(999999999), 1'b0);
		send_item(value_t'(10), 1'b0);
		send_item(value_t'(9), 1'b0);
		send_item(value_t'(100), 1'b0);
		send_item(value_t'(1), 1'b1);
		send_item('0, 1'b0);
		send_item('0, 1'b0);
		send_item('0, 1'b1);
		send_item(value_t'(5), 1'b0);
		send_item(value_t'(3), 1'b0);
		send_item(value_t'(5), 1'b0);
		send_item(value_t'(3), 1'b0);
		send_item(value_t'(5), 1'b1);
	endtask

	// exactly a full set, no truncation
	task automatic test_full_set();
		send_set(CAPACITY);
	endtask

	// set too large: the element with last is itself dropped, flag clears after
	task automatic test_truncated_set();
		for (int i = 0; i < CAPACITY; i++)
			send_item(pick_value(), 1'b0);
		send_item(pick_value(), 1'b1);
		send_item(value_t'(7), 1'b1);
	endtask

	// random sets, mostly small, some full or overfull
	task automatic test_random_sets(input int item_budget);
		int sent;
		int r;
		int size;
		sent = 0;
		while (sent < item_budget) begin
			r = $urandom_range(99);
			if (r < 70)
				size = $urandom_range(8, 1);
			else if (r < 85)
				size = $urandom_range(40, 9);
			else if (r < 93)
				size = CAPACITY;
			else
				size = $urandom_range(CAPACITY + 6, CAPACITY + 1);
			send_set(size);
			sent += size;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		item             = '0;
		gathered_dropped = 1'b0;
		sender_idle_pct  = 8;
		error_count      = 0;
		cycle_count      = 0;
		prev_value       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_values();
		test_digit_extremes();
		test_full_set();
		test_truncated_set();
		test_random_sets(70);
		sender_idle_pct = 75;
		test_random_sets(70);
		sender_idle_pct = 0;
		test_random_sets(70);

		// wait for the last set to drain
		start <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (2 * CAPACITY + 8) @(posedge clk);
		if (error_count == 0 && sorted_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
